// File: src/cooperative_task_scheduler_defines.svh
// Assertion helpers used by the scheduler datapath.
`ifndef COOPERATIVE_TASK_SCHEDULER_DEFINES_SVH
`define COOPERATIVE_TASK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cts_pkg.sv
`default_nettype none
package cts_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FREE_W      = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = 4;
    localparam int HANDLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int PEND_W      = 8;
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_DISP = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [HANDLE_W-1:0] task_handle;
        logic [TIME_W-1:0]   start_delay;
        logic [TIME_W-1:0]   repeat_period;
        logic [TIME_W-1:0]   slot_to_delete;
    } t_req_payload;

    typedef struct packed {
        logic load;
        logic ptr_inc;
        logic tick_step;
        logic tick_done;
        logic add_do;
        logic del_do;
        logic disp_step;
        logic disp_end;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic ptr_last;
        logic step_ok;
        logic cnt_full;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: src/cts_if.sv
`default_nettype none
interface cts_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] task_handle;
    logic [31:0] start_delay;
    logic [31:0] repeat_period;
    logic [31:0] slot_to_delete;

    modport source (output valid, req_type, task_handle, start_delay, repeat_period,
                    slot_to_delete, input ready);
    modport sink   (input valid, req_type, task_handle, start_delay, repeat_period,
                    slot_to_delete, output ready);
endinterface

interface cts_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot_index;
    logic        fail_flag;
    logic        run_valid;
    logic [15:0] run_handle;
    logic        last_result;

    modport source (output valid, slot_index, fail_flag, run_valid, run_handle,
                    last_result, input ready);
    modport sink   (input valid, slot_index, fail_flag, run_valid, run_handle,
                    last_result, output ready);
endinterface
`default_nettype wire

// File: src/cts_datapath.sv
`default_nettype none
`include "cooperative_task_scheduler_defines.svh"
module cts_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cts_pkg::t_req_payload i_payload,
    input  wire cts_pkg::t_dp_cmd      i_cmd,
    output cts_pkg::t_dp_sts           o_sts,
    cts_res_if.source                  o_res
);
    import cts_pkg::*;

    // Slot table.
    logic [NUM_SLOTS-1:0] r_valid;
    logic [HANDLE_W-1:0]  r_handle  [NUM_SLOTS];
    logic [TIME_W-1:0]    r_delay   [NUM_SLOTS];
    logic [TIME_W-1:0]    r_period  [NUM_SLOTS];
    logic [PEND_W-1:0]    r_pending [NUM_SLOTS];

    // Captured request.
    t_req_payload r_req;

    logic [SLOT_W-1:0] r_ptr;
    logic [CNT_W-1:0]  r_cnt;

    // A dispatch result is held back until it is known whether it is the last.
    logic                r_hold_valid;
    logic [IDX_W-1:0]    r_hold_idx;
    logic [HANDLE_W-1:0] r_hold_handle;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic                r_out_fail;
    logic                r_out_runv;
    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_out_last;

    logic [FREE_W-1:0]   free_idx;
    logic                table_full;
    logic                del_in_range;
    logic                del_ok;
    logic [SLOT_W-1:0]   del_slot;
    logic [SLOT_W-1:0]   add_slot;
    logic                hit;
    logic                out_free;
    logic                push;
    logic [IDX_W-1:0]    push_idx;
    logic                push_fail;
    logic                push_runv;
    logic [HANDLE_W-1:0] push_handle;
    logic                push_last;

    always_comb begin
        free_idx = FREE_W'(NUM_SLOTS);
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = FREE_W'(i);
            end
        end
    end

    assign table_full   = (free_idx == FREE_W'(NUM_SLOTS));
    assign add_slot     = free_idx[SLOT_W-1:0];
    assign del_in_range = (r_req.slot_to_delete < TIME_W'(NUM_SLOTS));
    assign del_slot     = r_req.slot_to_delete[SLOT_W-1:0];
    assign del_ok       = del_in_range && r_valid[del_slot];
    assign hit          = r_valid[r_ptr] && (r_pending[r_ptr] != '0);
    assign out_free     = !r_out_valid || o_res.ready;

    assign o_sts.out_free = out_free;
    assign o_sts.ptr_last = (r_ptr == SLOT_W'(NUM_SLOTS - 1));
    assign o_sts.step_ok  = !hit || !r_hold_valid || out_free;
    assign o_sts.cnt_full = (r_cnt == CNT_W'(MAX_RESULTS));

    always_comb begin
        push        = 1'b0;
        push_idx    = '0;
        push_fail   = 1'b0;
        push_runv   = 1'b0;
        push_handle = '0;
        push_last   = 1'b1;
        if (i_cmd.tick_done) begin
            push = 1'b1;
        end else if (i_cmd.add_do) begin
            push     = 1'b1;
            push_idx = IDX_W'(free_idx);
        end else if (i_cmd.del_do) begin
            push      = 1'b1;
            push_fail = !del_ok;
        end else if (i_cmd.disp_step && hit && r_hold_valid) begin
            push        = 1'b1;
            push_idx    = r_hold_idx;
            push_runv   = 1'b1;
            push_handle = r_hold_handle;
            push_last   = 1'b0;
        end else if (i_cmd.disp_end) begin
            push = 1'b1;
            if (r_hold_valid) begin
                push_idx    = r_hold_idx;
                push_runv   = 1'b1;
                push_handle = r_hold_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.add_do && !table_full) begin
                r_valid[add_slot] <= 1'b1;
            end
            if (i_cmd.del_do && del_ok) begin
                r_valid[del_slot] <= 1'b0;
            end
            // A one-shot task leaves the table once it has been dispatched.
            if (i_cmd.disp_step && hit && (r_period[r_ptr] == '0)) begin
                r_valid[r_ptr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_do && !table_full) begin
            r_handle[add_slot]  <= r_req.task_handle;
            r_delay[add_slot]   <= r_req.start_delay;
            r_period[add_slot]  <= r_req.repeat_period;
            r_pending[add_slot] <= (r_req.start_delay == '0) ? PEND_W'(1) : '0;
        end
        if (i_cmd.tick_step && r_valid[r_ptr]) begin
            if (r_delay[r_ptr] == '0) begin
                if (r_pending[r_ptr] != PEND_MAX) begin
                    r_pending[r_ptr] <= r_pending[r_ptr] + PEND_W'(1);
                end
                if (r_period[r_ptr] != '0) begin
                    r_delay[r_ptr] <= r_period[r_ptr];
                end
            end else begin
                r_delay[r_ptr] <= r_delay[r_ptr] - TIME_W'(1);
            end
        end
        if (i_cmd.disp_step && hit) begin
            r_pending[r_ptr] <= r_pending[r_ptr] - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_payload;
        end
        if (i_cmd.disp_step && hit) begin
            r_hold_idx    <= IDX_W'(r_ptr);
            r_hold_handle <= r_handle[r_ptr];
        end
        if (push) begin
            r_out_idx    <= push_idx;
            r_out_fail   <= push_fail;
            r_out_runv   <= push_runv;
            r_out_handle <= push_handle;
            r_out_last   <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_cnt        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ptr        <= '0;
                r_cnt        <= '0;
                r_hold_valid <= 1'b0;
            end else begin
                if (i_cmd.ptr_inc) begin
                    r_ptr <= r_ptr + SLOT_W'(1);
                end
                if (i_cmd.disp_step && hit) begin
                    r_cnt        <= r_cnt + CNT_W'(1);
                    r_hold_valid <= 1'b1;
                end
                if (i_cmd.disp_end) begin
                    r_hold_valid <= 1'b0;
                end
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.slot_index  = r_out_idx;
    assign o_res.fail_flag   = r_out_fail;
    assign o_res.run_valid   = r_out_runv;
    assign o_res.run_handle  = r_out_handle;
    assign o_res.last_result = r_out_last;

    `CTS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_RESULTS), "dispatch count overflow")
    `CTS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, push && r_out_valid, o_res.ready, "result overwritten before transaction")
    `CTS_ASSERT_NEXT(a_hold_set, i_clk, i_rst_n, i_cmd.disp_step && hit, r_hold_valid, "dispatched slot not held")

endmodule
`default_nettype wire

// File: src/cts_controller.sv
`default_nettype none
module cts_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire logic [1:0]       i_req_type,
    input  wire cts_pkg::t_dp_sts i_sts,
    output logic                  o_req_ready,
    output cts_pkg::t_dp_cmd      o_cmd
);
    import cts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_TICK_END,
        S_ADD,
        S_DEL,
        S_DISP,
        S_DISP_END
    } t_state;

    t_state r_state;
    t_state n_state;
    t_req_type req_type;

    assign req_type    = t_req_type'(i_req_type);
    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (req_type)
                        REQ_TICK: n_state = S_TICK;
                        REQ_ADD:  n_state = S_ADD;
                        REQ_DEL:  n_state = S_DEL;
                        REQ_DISP: n_state = S_DISP;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_TICK_END;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_TICK_END: begin
                if (i_sts.out_free) begin
                    o_cmd.tick_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DEL: begin
                if (i_sts.out_free) begin
                    o_cmd.del_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DISP: begin
                // A found slot may have to wait until the previous one is sent.
                if (i_sts.cnt_full) begin
                    n_state = S_DISP_END;
                end else if (i_sts.step_ok) begin
                    o_cmd.disp_step = 1'b1;
                    if (i_sts.ptr_last) begin
                        n_state = S_DISP_END;
                    end else begin
                        o_cmd.ptr_inc = 1'b1;
                    end
                end
            end
            S_DISP_END: begin
                if (i_sts.out_free) begin
                    o_cmd.disp_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: src/cooperative_task_scheduler.sv
`default_nettype none
// Time-triggered cooperative scheduler with a table of NUM_SLOTS task slots. Each
// request on i_req yields one or more transactions on o_res, the final one flagged
// by last_result. Tick and dispatch walk the table one slot per cycle through a
// single shared slot update path; a dispatch walk pauses while a found slot waits
// for the output register, and a dispatch that already emitted MAX_RESULTS tasks
// ends its walk early. A new request is taken once the previous one has handed its
// last result to the output register.
module cooperative_task_scheduler (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cts_req_if.sink   i_req,
    cts_res_if.source o_res
);
    import cts_pkg::*;

    t_dp_cmd      cmd;
    t_dp_sts      sts;
    t_req_payload payload;
    logic         req_ready;

    assign payload.task_handle    = i_req.task_handle;
    assign payload.start_delay    = i_req.start_delay;
    assign payload.repeat_period  = i_req.repeat_period;
    assign payload.slot_to_delete = i_req.slot_to_delete;
    assign i_req.ready            = req_ready;

    cts_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    cts_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_payload (payload),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int SINK_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_ITEMS     = 55;
    localparam int CALM_FROM        = 45;

    typedef struct {
        t_req_type           kind;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   target;
    } t_request;

    typedef struct {
        logic [IDX_W-1:0]    slot_index;
        logic                fail_flag;
        logic                run_valid;
        logic [HANDLE_W-1:0] run_handle;
        logic                last_result;
    } t_resp;

    typedef struct {
        t_request req;
        bit       typed;
        t_resp    resp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    cts_req_if req_if ();
    cts_res_if res_if ();

    cooperative_task_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow copy of the task table.
    logic                tbl_valid   [NUM_SLOTS];
    logic [HANDLE_W-1:0] tbl_handle  [NUM_SLOTS];
    logic [TIME_W-1:0]   tbl_delay   [NUM_SLOTS];
    logic [TIME_W-1:0]   tbl_period  [NUM_SLOTS];
    logic [PEND_W-1:0]   tbl_pending [NUM_SLOTS];

    t_resp awaited[$];
    t_resp head_resp;
    t_row  script[$];

    int mismatches  = 0;
    int stall_count = 0;
    bit calm        = 1'b0;
    bit hold_sink   = 1'b0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void clear_entry(input int s);
        tbl_valid[s]   = 1'b0;
        tbl_handle[s]  = '0;
        tbl_delay[s]   = '0;
        tbl_period[s]  = '0;
        tbl_pending[s] = '0;
    endfunction

    function automatic void apply_request(input t_request r);
        t_resp rs;
        int    s;
        int    n;
        rs = '{slot_index: '0, fail_flag: 1'b0, run_valid: 1'b0, run_handle: '0,
               last_result: 1'b1};
        n = 0;
        case (r.kind)
            REQ_TICK: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (tbl_valid[s]) begin
                        if (tbl_delay[s] == '0) begin
                            if (tbl_pending[s] != PEND_MAX) tbl_pending[s]++;
                            if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s];
                        end else begin
                            tbl_delay[s]--;
                        end
                    end
                end
                awaited.push_back(rs);
            end
            REQ_ADD: begin
                s = 0;
                while (s < NUM_SLOTS && tbl_valid[s]) s++;
                if (s < NUM_SLOTS) begin
                    tbl_valid[s]   = 1'b1;
                    tbl_handle[s]  = r.handle;
                    tbl_delay[s]   = r.delay;
                    tbl_period[s]  = r.period;
                    tbl_pending[s] = (r.delay == '0) ? PEND_W'(1) : '0;
                end
                rs.slot_index = IDX_W'(s);
                awaited.push_back(rs);
            end
            REQ_DEL: begin
                if (r.target < NUM_SLOTS && tbl_valid[r.target]) clear_entry(int'(r.target));
                else rs.fail_flag = 1'b1;
                awaited.push_back(rs);
            end
            default: begin
                for (s = 0; s < NUM_SLOTS && n < MAX_RESULTS; s++) begin
                    if (tbl_valid[s] && tbl_pending[s] != '0) begin
                        awaited.push_back('{slot_index: IDX_W'(s), fail_flag: 1'b0,
                                            run_valid: 1'b1, run_handle: tbl_handle[s],
                                            last_result: 1'b0});
                        n++;
                        tbl_pending[s]--;
                        // A one-shot task leaves the table even with runs still owed.
                        if (tbl_period[s] == '0) clear_entry(s);
                    end
                end
                if (n == 0) awaited.push_back(rs);
                else awaited[awaited.size()-1].last_result = 1'b1;
            end
        endcase
    endfunction

    function automatic t_row mk_row(input t_req_type kind, input logic [HANDLE_W-1:0] handle,
                                    input logic [TIME_W-1:0] delay,
                                    input logic [TIME_W-1:0] period,
                                    input logic [TIME_W-1:0] target, input bit typed,
                                    input int idx, input bit fail);
        t_row row;
        row.req   = '{kind: kind, handle: handle, delay: delay, period: period, target: target};
        row.typed = typed;
        row.resp  = '{slot_index: IDX_W'(idx), fail_flag: fail, run_valid: 1'b0,
                      run_handle: '0, last_result: 1'b1};
        return row;
    endfunction

    task automatic send_request(input t_request r, input int gap, input bit typed,
                                input t_resp typed_resp);
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid          <= 1'b1;
        req_if.req_type       <= r.kind;
        req_if.task_handle    <= r.handle;
        req_if.start_delay    <= r.delay;
        req_if.repeat_period  <= r.period;
        req_if.slot_to_delete <= r.target;
        do @(posedge i_clk); while (!req_if.ready);
        apply_request(r);
        if (typed) begin
            void'(awaited.pop_back());
            awaited.push_back(typed_resp);
        end
    endtask

    // Stimulus.
    initial begin
        t_request r;
        t_resp    no_resp;
        int       live[$];
        int       pick;
        int       gap;
        int       burst_left;
        int       i;
        int       s;

        no_resp    = '{slot_index: '0, fail_flag: 1'b0, run_valid: 1'b0, run_handle: '0,
                       last_result: 1'b0};
        burst_left = 0;
        i_rst_n    = 1'b0;
        req_if.valid          = 1'b0;
        req_if.req_type       = REQ_TICK;
        req_if.task_handle    = '0;
        req_if.start_delay    = '0;
        req_if.repeat_period  = '0;
        req_if.slot_to_delete = '0;
        for (s = 0; s < NUM_SLOTS; s++) clear_entry(s);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, error paths, fill to full, then mixed traffic.
        script.push_back(mk_row(REQ_DISP, '0, '0, '0, '0, 1, 0, 0));
        script.push_back(mk_row(REQ_TICK, '0, '0, '0, '0, 1, 0, 0));
        script.push_back(mk_row(REQ_DEL, '0, '0, '0, '0, 1, 0, 1));
        script.push_back(mk_row(REQ_DEL, '0, '0, '0, 32'hFFFF_FFFF, 1, 0, 1));
        script.push_back(mk_row(REQ_ADD, 16'hFFFF, '0, '0, '0, 1, 0, 0));
        script.push_back(mk_row(REQ_ADD, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1, 1, 0));
        script.push_back(mk_row(REQ_ADD, 16'h1234, 32'd0, 32'd1, '0, 1, 2, 0));
        script.push_back(mk_row(REQ_ADD, 16'hA5A5, 32'd2, 32'd0, '0, 1, 3, 0));
        script.push_back(mk_row(REQ_ADD, 16'h5A5A, 32'd1, 32'd3, '0, 1, 4, 0));
        script.push_back(mk_row(REQ_ADD, 16'h0001, 32'd0, 32'd0, '0, 1, 5, 0));
        script.push_back(mk_row(REQ_ADD, 16'h8000, 32'd3, 32'd2, '0, 1, 6, 0));
        script.push_back(mk_row(REQ_ADD, 16'h7FFF, 32'd0, 32'hFFFF_FFFF, '0, 1, 7, 0));
        script.push_back(mk_row(REQ_ADD, 16'h0F0F, 32'd5, 32'd5, '0, 1, NUM_SLOTS, 0));
        script.push_back(mk_row(REQ_DEL, '0, '0, '0, 32'(NUM_SLOTS), 1, 0, 1));
        script.push_back(mk_row(REQ_DEL, '0, '0, '0, 32'h8000_0000, 1, 0, 1));
        script.push_back(mk_row(REQ_TICK, '0, '0, '0, '0, 1, 0, 0));
        script.push_back(mk_row(REQ_DISP, '0, '0, '0, '0, 0, 0, 0));
        script.push_back(mk_row(REQ_DEL, '0, '0, '0, 32'd1, 1, 0, 0));
        script.push_back(mk_row(REQ_DEL, '0, '0, '0, 32'd1, 1, 0, 1));
        script.push_back(mk_row(REQ_TICK, '0, '0, '0, '0, 0, 0, 0));
        script.push_back(mk_row(REQ_TICK, '0, '0, '0, '0, 0, 0, 0));
        script.push_back(mk_row(REQ_DISP, '0, '0, '0, '0, 0, 0, 0));
        script.push_back(mk_row(REQ_TICK, '0, '0, '0, '0, 0, 0, 0));
        script.push_back(mk_row(REQ_DISP, '0, '0, '0, '0, 0, 0, 0));
        script.push_back(mk_row(REQ_DISP, '0, '0, '0, '0, 0, 0, 0));

        foreach (script[k]) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            send_request(script[k].req, gap, script[k].typed, script[k].resp);
        end

        // Let a one-shot task collect several pending runs; one dispatch still drops it.
        r = '{kind: REQ_ADD, handle: 16'hC0DE, delay: '0, period: '0, target: '0};
        send_request(r, 0, 0, no_resp);
        r.kind = REQ_TICK;
        repeat (20) send_request(r, ($urandom_range(0, 7) == 0) ? 1 : 0, 0, no_resp);
        r.kind = REQ_DISP;
        repeat (2) send_request(r, 0, 0, no_resp);

        // Start the random traffic from an empty table.
        r.kind = REQ_DEL;
        for (s = 0; s < NUM_SLOTS; s++) begin
            r.target = 32'(s);
            send_request(r, 0, 0, no_resp);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == CALM_FROM) calm = 1'b1;
            if (i == 15) begin
                hold_sink  = 1'b1;
                burst_left = 12;
            end
            if (i == 30) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                while (awaited.size() != 0) @(posedge i_clk);
            end

            r.handle = 16'($urandom);
            pick     = $urandom_range(0, 99);
            if (pick < 30) r.kind = REQ_TICK;
            else if (pick < 55) r.kind = REQ_ADD;
            else if (pick < 70) r.kind = REQ_DEL;
            else r.kind = REQ_DISP;

            pick    = $urandom_range(0, 9);
            r.delay = (pick < 7) ? 32'($urandom_range(0, 4)) : (pick < 9) ? '0 : 32'($urandom);
            pick     = $urandom_range(0, 9);
            r.period = (pick < 6) ? 32'($urandom_range(1, 4)) : (pick < 9) ? '0 : 32'($urandom);

            live.delete();
            for (s = 0; s < NUM_SLOTS; s++) if (tbl_valid[s]) live.push_back(s);
            pick = $urandom_range(0, 9);
            if (pick < 7 && live.size() != 0) r.target = 32'(live[$urandom_range(0, live.size()-1)]);
            else if (pick < 9) r.target = 32'($urandom_range(0, 15));
            else r.target = 32'($urandom);

            if (calm || burst_left > 0) gap = 0;
            else gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            if (burst_left > 0) burst_left--;
            send_request(r, gap, 0, no_resp);
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // Result side back-pressure.
    initial begin
        bit held;
        held         = 1'b0;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink && !held) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited.size() == 0) begin
                $error("unexpected result transaction: slot_index %0d run_handle %0h",
                       res_if.slot_index, res_if.run_handle);
                mismatches++;
            end else begin
                head_resp = awaited.pop_front();
                if (res_if.slot_index !== head_resp.slot_index) begin
                    $error("slot_index: expected %0d, actual %0d",
                           head_resp.slot_index, res_if.slot_index);
                    mismatches++;
                end
                if (res_if.fail_flag !== head_resp.fail_flag) begin
                    $error("fail_flag: expected %0d, actual %0d",
                           head_resp.fail_flag, res_if.fail_flag);
                    mismatches++;
                end
                if (res_if.run_valid !== head_resp.run_valid) begin
                    $error("run_valid: expected %0d, actual %0d",
                           head_resp.run_valid, res_if.run_valid);
                    mismatches++;
                end
                if (res_if.run_handle !== head_resp.run_handle) begin
                    $error("run_handle: expected %0h, actual %0h",
                           head_resp.run_handle, res_if.run_handle);
                    mismatches++;
                end
                if (res_if.last_result !== head_resp.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           head_resp.last_result, res_if.last_result);
                    mismatches++;
                end
            end
        end
    end

    // The watchdog restarts on every transaction on either channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
`default_nettype wire

// File: cooperative_task_scheduler.f
+incdir+src
src/cts_pkg.sv
src/cts_if.sv
src/cts_datapath.sv
src/cts_controller.sv
src/cooperative_task_scheduler.sv
bench/tb.sv
